// ----- src/rtd_pkg.sv -----
package rtd_pkg;

   localparam int ADC_BITS      = 12;
   localparam int TABLE_ENTRIES = 51;
   localparam int SUM_W         = 20;
   localparam int CNT_W         = 9;
   localparam int TEMP_W        = 9;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int DIFF_W        = 8;
   localparam int PROD_W        = DIFF_W + 3;
   localparam int STEP_INT      = 5;
   localparam int STEP_W        = $clog2(SUM_W);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [CNT_W-1:0]         DEFAULT_COUNT = 9'd200;
   localparam logic [CNT_W-1:0]         MAX_COUNT     = 9'd256;
   localparam logic [ADC_BITS-1:0]      ADC_FULL      = {ADC_BITS{1'b1}};
   localparam logic signed [TEMP_W-1:0] MIN_TEMP      = -9'sd70;
   localparam logic signed [TEMP_W-1:0] MAX_TEMP      = 9'sd180;

   localparam logic [ADC_BITS-1:0] ROM_ADC [TABLE_ENTRIES] = '{
      12'd1719, 12'd1746, 12'd1773, 12'd1799, 12'd1825, 12'd1850, 12'd1874, 12'd1899,
      12'd1923, 12'd1946, 12'd1969, 12'd1991, 12'd2013, 12'd2035, 12'd2048, 12'd2067,
      12'd2086, 12'd2106, 12'd2124, 12'd2143, 12'd2160, 12'd2178, 12'd2195, 12'd2212,
      12'd2229, 12'd2245, 12'd2261, 12'd2277, 12'd2292, 12'd2307, 12'd2322, 12'd2337,
      12'd2351, 12'd2365, 12'd2379, 12'd2392, 12'd2406, 12'd2419, 12'd2432, 12'd2444,
      12'd2456, 12'd2469, 12'd2480, 12'd2492, 12'd2503, 12'd2515, 12'd2526, 12'd2536,
      12'd2547, 12'd2558, 12'd2568
   };

   typedef struct packed {
      logic              fire;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_SEARCH,
      BACK_INTERP
   } back_state_type;

   function automatic logic [ADC_BITS-1:0] rom_adc(input logic [IDX_W-1:0] idx);
      logic [ADC_BITS-1:0] val;
      val = '0;
      if (int'(idx) < TABLE_ENTRIES) begin
         val = ROM_ADC[idx];
      end
      return val;
   endfunction

endpackage

// ----- src/rtd_average_lut_interpolate_top.sv -----
// RTD sample averaging with piecewise-linear temperature lookup.
// Input queue side: present a 12-bit ADC sample on req_adc_sample with
// req_push; the word is taken on a clock edge where req_full is low.
// Result queue side: while rsp_empty is low the oldest result word is on
// rsp_reported_temp, rsp_temperature_c, rsp_average_adc, rsp_average_ready;
// raise rsp_pop to take it. One result word per sample, in order.
// csr_write_enable / csr_write_data set the samples per average (0 acts
// as 1, above 256 acts as 256); write only while the block is idle.
// A sample that does not close an average passes the job queue and the
// output register, one word per cycle while the back end is idle and the
// receiver takes results. A closing sample goes through the bit-serial
// sum/count divider, then the segment search walks the 51-entry table one
// entry a cycle, then the BACK_INTERP state interpolates. A 4-word queue
// sits between accumulator and back end, so samples keep flowing meanwhile.
// Reset (synchronous, active high) clears sum, counter, held values and
// both queues, and sets the count to 200. If the receiver stalls, results
// hold in the output register, the queue fills and req_full rises.
module rtd_average_lut_interpolate_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [rtd_pkg::ADC_BITS-1:0]        req_adc_sample,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [rtd_pkg::TEMP_W-1:0]   rsp_reported_temp,
   output logic signed [rtd_pkg::TEMP_W-1:0]   rsp_temperature_c,
   output logic [rtd_pkg::ADC_BITS-1:0]        rsp_average_adc,
   output logic                                rsp_average_ready,
   input  logic                                csr_write_enable,
   input  logic [rtd_pkg::CNT_W-1:0]           csr_write_data
);

   logic             job_push;
   logic             job_full;
   logic             job_pop;
   logic             job_empty;
   rtd_pkg::job_type job_in;
   rtd_pkg::job_type job_out;

   rtd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_adc_sample   (req_adc_sample),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .job_push         (job_push),
      .job_full         (job_full),
      .job              (job_in)
   );

   rtd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_in),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_out)
   );

   rtd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (!job_empty),
      .job               (job_out),
      .job_pop           (job_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_reported_temp (rsp_reported_temp),
      .rsp_temperature_c (rsp_temperature_c),
      .rsp_average_adc   (rsp_average_adc),
      .rsp_average_ready (rsp_average_ready)
   );

endmodule

// ----- src/rtd_front.sv -----
module rtd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [rtd_pkg::ADC_BITS-1:0] req_adc_sample,
   input  logic                         csr_write_enable,
   input  logic [rtd_pkg::CNT_W-1:0]    csr_write_data,
   output logic                         job_push,
   input  logic                         job_full,
   output rtd_pkg::job_type             job
);

   logic [rtd_pkg::CNT_W-1:0] count_cfg_ff, count_cfg_in;
   logic [rtd_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [rtd_pkg::CNT_W-1:0] counter_ff, counter_in;
   logic [rtd_pkg::CNT_W-1:0] eff;
   logic [rtd_pkg::SUM_W-1:0] sum_next;
   logic [rtd_pkg::CNT_W-1:0] counter_next;
   logic                      fire;

   assign req_full = job_full;
   assign job_push = req_push && !job_full;

   always_comb begin
      priority if (count_cfg_ff == '0) begin
         eff = rtd_pkg::CNT_W'(1);
      end else if (count_cfg_ff > rtd_pkg::MAX_COUNT) begin
         eff = rtd_pkg::MAX_COUNT;
      end else begin
         eff = count_cfg_ff;
      end
   end

   always_comb begin
      sum_next     = sum_ff + rtd_pkg::SUM_W'(req_adc_sample);
      counter_next = counter_ff + rtd_pkg::CNT_W'(1);
      fire         = counter_next >= eff;
      job.fire     = fire;
      job.sum      = sum_next;
      job.count    = eff;
      count_cfg_in = csr_write_enable ? csr_write_data : count_cfg_ff;
      sum_in       = sum_ff;
      counter_in   = counter_ff;
      if (job_push) begin
         sum_in     = fire ? '0 : sum_next;
         counter_in = fire ? '0 : counter_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_cfg_ff <= rtd_pkg::DEFAULT_COUNT;
         sum_ff       <= '0;
         counter_ff   <= '0;
      end else begin
         count_cfg_ff <= count_cfg_in;
         sum_ff       <= sum_in;
         counter_ff   <= counter_in;
      end
   end

endmodule

// ----- src/rtd_queue.sv -----
module rtd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rtd_pkg::job_type push_data,
   input  logic             pop,
   output logic             empty,
   output rtd_pkg::job_type pop_data
);

   rtd_pkg::job_type            data_ff [rtd_pkg::QUEUE_DEPTH];
   logic [rtd_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rtd_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rtd_pkg::QPTR_W:0]    count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full     = count_ff == (rtd_pkg::QPTR_W + 1)'(rtd_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + rtd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + rtd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (rtd_pkg::QPTR_W + 1)'(do_push)
                  - (rtd_pkg::QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/rtd_back.sv -----
module rtd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   input  rtd_pkg::job_type                    job,
   output logic                                job_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [rtd_pkg::TEMP_W-1:0]   rsp_reported_temp,
   output logic signed [rtd_pkg::TEMP_W-1:0]   rsp_temperature_c,
   output logic [rtd_pkg::ADC_BITS-1:0]        rsp_average_adc,
   output logic                                rsp_average_ready
);

   rtd_pkg::back_state_type              state_ff, state_in;
   logic [rtd_pkg::CNT_W-1:0]            rem_ff, rem_in;
   logic [rtd_pkg::SUM_W-1:0]            quo_ff, quo_in;
   logic [rtd_pkg::CNT_W-1:0]            div_ff, div_in;
   logic [rtd_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [rtd_pkg::ADC_BITS-1:0]         avg_ff, avg_in;
   logic [rtd_pkg::IDX_W-1:0]            idx_ff, idx_in;
   logic signed [rtd_pkg::TEMP_W-1:0]    held_temp_ff, held_temp_in;
   logic [rtd_pkg::ADC_BITS-1:0]         held_avg_ff, held_avg_in;
   logic                                 out_valid_ff, out_valid_in;
   logic signed [rtd_pkg::TEMP_W-1:0]    out_temp_ff, out_temp_in;
   logic [rtd_pkg::ADC_BITS-1:0]         out_avg_ff, out_avg_in;
   logic                                 out_ready_ff, out_ready_in;

   logic                                 slot_free;
   logic [rtd_pkg::CNT_W:0]              shifted;
   logic                                 qbit;
   logic [rtd_pkg::SUM_W-1:0]            quo_next;
   logic [rtd_pkg::IDX_W-1:0]            idx_next;
   logic [rtd_pkg::ADC_BITS-1:0]         seg_lo;
   logic [rtd_pkg::ADC_BITS-1:0]         seg_hi;
   logic [rtd_pkg::DIFF_W-1:0]           seg_d;
   logic [rtd_pkg::DIFF_W-1:0]           seg_x;
   logic [rtd_pkg::PROD_W-1:0]           prod;
   logic [2:0]                           frac_q;
   logic                                 exact;
   logic signed [rtd_pkg::TEMP_W-1:0]    base;
   logic [2:0]                           adj;
   logic signed [rtd_pkg::TEMP_W-1:0]    interp_temp;
   logic signed [rtd_pkg::TEMP_W-1:0]    fin_temp;
   logic                                 finish;

   assign rsp_empty         = !out_valid_ff;
   assign rsp_temperature_c = out_temp_ff;
   assign rsp_reported_temp = out_temp_ff + rtd_pkg::TEMP_W'(1);
   assign rsp_average_adc   = out_avg_ff;
   assign rsp_average_ready = out_ready_ff;
   assign slot_free         = !out_valid_ff || rsp_pop;

   always_comb begin
      shifted  = {rem_ff, quo_ff[rtd_pkg::SUM_W-1]};
      qbit     = shifted >= {1'b0, div_ff};
      quo_next = {quo_ff[rtd_pkg::SUM_W-2:0], qbit};
      idx_next = idx_ff + rtd_pkg::IDX_W'(1);
   end

   always_comb begin
      seg_lo = rtd_pkg::rom_adc(idx_ff);
      seg_hi = rtd_pkg::rom_adc(idx_next);
      seg_d  = rtd_pkg::DIFF_W'(seg_hi - seg_lo);
      seg_x  = rtd_pkg::DIFF_W'(avg_ff - seg_lo);
      prod   = rtd_pkg::PROD_W'(seg_x) * rtd_pkg::PROD_W'(rtd_pkg::STEP_INT);
      frac_q = '0;
      for (int k = 1; k <= rtd_pkg::STEP_INT; k++) begin
         if (prod >= rtd_pkg::PROD_W'(k) * rtd_pkg::PROD_W'(seg_d)) begin
            frac_q = frac_q + 3'd1;
         end
      end
      exact = prod == rtd_pkg::PROD_W'(frac_q) * rtd_pkg::PROD_W'(seg_d);
      base  = rtd_pkg::MIN_TEMP
              + $signed(rtd_pkg::TEMP_W'(idx_ff) * rtd_pkg::TEMP_W'(rtd_pkg::STEP_INT));
      adj   = frac_q + 3'((base < 0) && !exact);
      interp_temp = base + $signed(rtd_pkg::TEMP_W'(adj));
   end

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      avg_in       = avg_ff;
      idx_in       = idx_ff;
      held_temp_in = held_temp_ff;
      held_avg_in  = held_avg_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_temp_in  = out_temp_ff;
      out_avg_in   = out_avg_ff;
      out_ready_in = out_ready_ff;
      job_pop      = 1'b0;
      finish       = 1'b0;
      fin_temp     = interp_temp;
      unique case (state_ff)
         rtd_pkg::BACK_IDLE: begin
            if (job_valid && slot_free) begin
               job_pop = 1'b1;
               if (job.fire) begin
                  rem_in   = '0;
                  quo_in   = job.sum;
                  div_in   = job.count;
                  step_in  = '0;
                  state_in = rtd_pkg::BACK_DIV;
               end else begin
                  out_valid_in = 1'b1;
                  out_temp_in  = held_temp_ff;
                  out_avg_in   = held_avg_ff;
                  out_ready_in = 1'b0;
               end
            end
         end
         rtd_pkg::BACK_DIV: begin
            rem_in  = qbit ? rtd_pkg::CNT_W'(shifted - {1'b0, div_ff})
                           : rtd_pkg::CNT_W'(shifted);
            quo_in  = quo_next;
            step_in = step_ff + rtd_pkg::STEP_W'(1);
            if (step_ff == rtd_pkg::STEP_W'(rtd_pkg::SUM_W - 1)) begin
               avg_in   = (|quo_next[rtd_pkg::SUM_W-1:rtd_pkg::ADC_BITS])
                          ? rtd_pkg::ADC_FULL : quo_next[rtd_pkg::ADC_BITS-1:0];
               idx_in   = '0;
               state_in = rtd_pkg::BACK_SEARCH;
            end
         end
         rtd_pkg::BACK_SEARCH: begin
            priority if (avg_ff <= rtd_pkg::rom_adc('0)) begin
               finish   = 1'b1;
               fin_temp = rtd_pkg::MIN_TEMP;
            end else if (avg_ff >=
                         rtd_pkg::rom_adc(rtd_pkg::IDX_W'(rtd_pkg::TABLE_ENTRIES - 1))) begin
               finish   = 1'b1;
               fin_temp = rtd_pkg::MAX_TEMP;
            end else if (avg_ff <= seg_hi) begin
               state_in = rtd_pkg::BACK_INTERP;
            end else begin
               idx_in = idx_next;
            end
         end
         rtd_pkg::BACK_INTERP: begin
            finish = 1'b1;
         end
         default: begin
            state_in = rtd_pkg::BACK_IDLE;
         end
      endcase
      if (finish) begin
         held_temp_in = fin_temp;
         held_avg_in  = avg_ff;
         out_valid_in = 1'b1;
         out_temp_in  = fin_temp;
         out_avg_in   = avg_ff;
         out_ready_in = 1'b1;
         state_in     = rtd_pkg::BACK_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtd_pkg::BACK_IDLE;
         held_temp_ff <= '0;
         held_avg_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_temp_ff <= held_temp_in;
         held_avg_ff  <= held_avg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_ff       <= div_in;
      step_ff      <= step_in;
      avg_ff       <= avg_in;
      idx_ff       <= idx_in;
      out_temp_ff  <= out_temp_in;
      out_avg_ff   <= out_avg_in;
      out_ready_ff <= out_ready_in;
   end

endmodule

// ----- src/rtd_checker.sv -----
module rtd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic signed [rtd_pkg::TEMP_W-1:0]   rsp_reported_temp,
   input logic signed [rtd_pkg::TEMP_W-1:0]   rsp_temperature_c,
   input logic [rtd_pkg::ADC_BITS-1:0]        rsp_average_adc,
   input logic                                rsp_average_ready
);

   a_reset_clears : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_temperature_c)
                                 && $stable(rsp_average_adc) && $stable(rsp_average_ready))
      else $error("stalled result word changed");

   a_reported_offset : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_reported_temp == rsp_temperature_c + rtd_pkg::TEMP_W'(1))
      else $error("reported temperature not held value plus one");

   a_update_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_average_ready |->
         rsp_temperature_c >= rtd_pkg::MIN_TEMP && rsp_temperature_c <= rtd_pkg::MAX_TEMP)
      else $error("updated temperature outside table range");

endmodule

bind rtd_average_lut_interpolate_top rtd_checker u_checker (.*);
